// ----- sv/sgl_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sgl_pkg: shared types and constants of the segment list builder
// Command and status codes, register map and the structs that connect the
// controller, the datapath and the register block.
// ---------------------------------------------------------------------------
package sgl_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOIDX = 2'd2;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	// Register index, taken from paddr[4:3].
	localparam logic [1:0] REG_MAX_SEG_SIZE = 2'd0;
	localparam logic [1:0] REG_BOUNDARY     = 2'd1;
	localparam logic [1:0] REG_MAX_SEGS     = 2'd2;

	localparam logic [31:0] MAX_SEG_SIZE_RST = 32'd65536;
	localparam logic [6:0]  MAX_SEGS_RST     = 7'd64;

	typedef struct packed {
		logic [31:0] max_seg_size;  // zero already replaced by one
		logic [32:0] bnd;           // highest set bit of boundary, or zero
		logic [32:0] bnd_mask;      // bnd - 1 when bnd is nonzero, else zero
		logic [6:0]  max_segs;
	} cfg_t;

	typedef struct packed {
		logic       accept;
		logic       piece_en;
		logic       commit;
		logic       out_load;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       len_zero;
		logic       merge_ok;
		logic       full;
		logic       last_piece;
	} dp_stat_t;

	// Sets every bit below the highest set bit.
	function automatic logic [32:0] smear(input logic [32:0] v);
		logic [32:0] m;
		m = v;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		m = m | (m >> 32);
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- sv/sgl_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sgl_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sgl_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                          wdata,
	input  wire                                      re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/sgl_regs.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sgl_regs: configuration registers
// APB-style register file holding segment size, boundary and table size.
// ---------------------------------------------------------------------------
module sgl_regs (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [sgl_pkg::PADDR_W-1:0]     paddr,
	input  wire  [sgl_pkg::PDATA_W-1:0]     pwdata,
	output logic [sgl_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	output sgl_pkg::cfg_t                   cfg
);

	logic [31:0] max_seg_size_q;
	logic [32:0] boundary_q;
	logic [6:0]  max_segs_q;
	logic [32:0] bnd_q;
	logic [32:0] bnd_mask_q;
	logic [32:0] smeared;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign smeared = sgl_pkg::smear(boundary_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_size_q <= sgl_pkg::MAX_SEG_SIZE_RST;
			boundary_q     <= 33'd0;
			max_segs_q     <= sgl_pkg::MAX_SEGS_RST;
			bnd_q          <= 33'd0;
			bnd_mask_q     <= 33'd0;
		end else begin
			if (wr_en) begin
				case (reg_idx)
					sgl_pkg::REG_MAX_SEG_SIZE: max_seg_size_q <= pwdata[31:0];
					sgl_pkg::REG_BOUNDARY:     boundary_q     <= pwdata[32:0];
					sgl_pkg::REG_MAX_SEGS:     max_segs_q     <= pwdata[6:0];
					default: ;
				endcase
			end
			// The boundary decode is registered and follows the raw register in the next cycle.
			bnd_q      <= smeared ^ (smeared >> 1);
			bnd_mask_q <= smeared >> 1;
		end
	end

	always_comb begin
		case (reg_idx)
			sgl_pkg::REG_MAX_SEG_SIZE: prdata = {32'd0, max_seg_size_q};
			sgl_pkg::REG_BOUNDARY:     prdata = {31'd0, boundary_q};
			sgl_pkg::REG_MAX_SEGS:     prdata = {57'd0, max_segs_q};
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.max_seg_size = (max_seg_size_q == 32'd0) ? 32'd1 : max_seg_size_q;
		cfg.bnd          = bnd_q;
		cfg.bnd_mask     = bnd_mask_q;
		cfg.max_segs     = max_segs_q;
	end

endmodule
`default_nettype wire

// ----- sv/sgl_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sgl_ctrl: sequencing controller
// Accepts one item at a time, steps the datapath piece by piece and hands
// the result to the output register.
// ---------------------------------------------------------------------------
module sgl_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	input  sgl_pkg::dp_stat_t   stat,
	output sgl_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_PIECE  = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic [1:0] res_status_q;
	logic [1:0] res_status_nxt;
	logic       out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt      = state_q;
		res_status_nxt = res_status_q;
		cmd            = '0;
		cmd.status     = res_status_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept     = 1'b1;
					res_status_nxt = sgl_pkg::ST_OK;
					if (stat.command == sgl_pkg::CMD_APPEND && !stat.len_zero) begin
						state_nxt = S_PIECE;
					end else begin
						state_nxt = S_FIN;
					end
				end
			end
			S_PIECE: begin
				cmd.piece_en = 1'b1;
				state_nxt    = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.merge_ok || !stat.full) begin
					cmd.commit = 1'b1;
					state_nxt  = stat.last_piece ? S_FIN : S_PIECE;
				end else begin
					res_status_nxt = sgl_pkg::ST_FULL;
					state_nxt      = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= sgl_pkg::ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			res_status_q <= res_status_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/sgl_dp.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sgl_dp: segment table datapath
// Holds the range being appended, cuts pieces, merges or adds segments in
// the table memory and forms the result.
// ---------------------------------------------------------------------------
module sgl_dp #(
	parameter int SEG_DEPTH = 64,
	parameter int ADDR_BITS = 48
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sgl_pkg::cfg_t         cfg,
	input  sgl_pkg::dp_cmd_t      cmd,
	output sgl_pkg::dp_stat_t     stat,
	input  wire  [1:0]            command,
	input  wire  [ADDR_BITS-1:0]  phys_addr,
	input  wire  [31:0]           range_len,
	input  wire  [5:0]            seg_index,
	output logic [1:0]            status,
	output logic [6:0]            seg_count,
	output logic [ADDR_BITS-1:0]  seg_phys,
	output logic [31:0]           seg_len
);

	localparam int AW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
	localparam int TW = $clog2(SEG_DEPTH + 1);
	localparam int CW = (TW > 7) ? TW : 7;
	localparam int IW = (AW > 6) ? AW : 6;
	localparam int RW = ADDR_BITS + 32;
	localparam logic [CW-1:0] DEPTH_C = CW'(SEG_DEPTH);

	logic [1:0]           cmd_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [31:0]          len_q;
	logic [5:0]           idx_q;
	logic [31:0]          piece_q;
	logic [TW-1:0]        total_q;
	logic [ADDR_BITS-1:0] last_start_q;
	logic [31:0]          last_len_q;
	logic [ADDR_BITS:0]   last_end_q;   // exclusive end, carry kept

	logic [32:0]          addr_lo;
	logic [32:0]          room;
	logic [31:0]          piece_a;
	logic [31:0]          piece_nxt;
	logic [32:0]          merged;
	logic [ADDR_BITS:0]   win_mask;
	logic                 crosses;
	logic                 contig;
	logic                 merge_ok;
	logic [CW-1:0]        total_c;
	logic                 full;
	logic [TW-1:0]        total_m1;
	logic [ADDR_BITS:0]   new_end;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [RW-1:0]        ram_wdata;
	logic [IW-1:0]        idx_w;
	logic [AW-1:0]        ram_raddr;
	logic [RW-1:0]        ram_rdata;
	logic                 rd_ok;

	// Piece length: smallest of remaining length, segment size and room
	// left before the next boundary.
	assign addr_lo   = 33'(addr_q);
	assign room      = cfg.bnd - (addr_lo & cfg.bnd_mask);
	assign piece_a   = (len_q < cfg.max_seg_size) ? len_q : cfg.max_seg_size;
	assign piece_nxt = (cfg.bnd != 33'd0 && room < {1'b0, piece_a}) ? room[31:0] : piece_a;

	// A contiguous piece never crosses a boundary itself, so the merged
	// segment crosses exactly when its start and the old end differ in window.
	assign win_mask = ~((ADDR_BITS + 1)'(cfg.bnd_mask));
	assign crosses  = (cfg.bnd != 33'd0)
		&& (((({1'b0, last_start_q}) ^ last_end_q) & win_mask) != '0);
	assign contig   = (last_end_q[ADDR_BITS-1:0] == addr_q);
	assign merged   = {1'b0, last_len_q} + {1'b0, piece_q};
	assign merge_ok = (total_q != '0) && contig && !crosses
		&& (merged <= {1'b0, cfg.max_seg_size});

	assign total_c  = CW'(total_q);
	assign full     = (total_c >= CW'(cfg.max_segs)) || (total_c >= DEPTH_C);
	assign total_m1 = total_q - TW'(1);
	assign new_end  = {1'b0, addr_q} + (ADDR_BITS + 1)'(piece_q);

	always_comb begin
		stat.command    = command;
		stat.len_zero   = (range_len == 32'd0);
		stat.merge_ok   = merge_ok;
		stat.full       = full;
		stat.last_piece = (len_q == piece_q);
	end

	assign ram_we    = cmd.commit;
	assign ram_waddr = merge_ok ? total_m1[AW-1:0] : total_q[AW-1:0];
	assign ram_wdata = merge_ok ? {last_start_q, merged[31:0]} : {addr_q, piece_q};
	assign idx_w     = IW'(seg_index);
	assign ram_raddr = idx_w[AW-1:0];

	sgl_ram #(
		.WIDTH (RW),
		.DEPTH (SEG_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ok = (CW'(idx_q) < total_c) && (CW'(idx_q) < DEPTH_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			if (cmd.accept && command == sgl_pkg::CMD_CLEAR) begin
				total_q <= '0;
			end else if (cmd.commit && !merge_ok) begin
				total_q <= total_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= command;
			addr_q <= phys_addr;
			len_q  <= range_len;
			idx_q  <= seg_index;
		end
		if (cmd.piece_en) begin
			piece_q <= piece_nxt;
		end
		if (cmd.commit) begin
			addr_q <= new_end[ADDR_BITS-1:0];
			len_q  <= len_q - piece_q;
			if (merge_ok) begin
				last_len_q <= merged[31:0];
				last_end_q <= last_end_q + (ADDR_BITS + 1)'(piece_q);
			end else begin
				last_start_q <= addr_q;
				last_len_q   <= piece_q;
				last_end_q   <= new_end;
			end
		end
		if (cmd.out_load) begin
			seg_count <= total_c[6:0];
			if (cmd_q == sgl_pkg::CMD_READ) begin
				status   <= rd_ok ? sgl_pkg::ST_OK : sgl_pkg::ST_NOIDX;
				seg_phys <= rd_ok ? ram_rdata[RW-1:32] : '0;
				seg_len  <= rd_ok ? ram_rdata[31:0] : 32'd0;
			end else begin
				status   <= cmd.status;
				seg_phys <= '0;
				seg_len  <= 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/sg_segment_list_builder_top.sv -----
`default_nettype none
// Clear, read and empty append go from accept straight to the final state; an append
// is cut into pieces, and each piece passes the piece and commit states first.
// Flow: one item at a time; each piece is sized in the piece state and then merged
// or added in the commit state through the table memory write port.
// Reset clears the segment count and loads register defaults; the table contents
// stay undefined and need no clearing pass.
// ---------------------------------------------------------------------------
// sg_segment_list_builder_top: scatter/gather segment table builder
// Stream in commands, stream out one result per command; APB-style registers.
// ---------------------------------------------------------------------------
module sg_segment_list_builder_top #(
	parameter int SEG_DEPTH = 64,
	parameter int ADDR_BITS = 48
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      s_tvalid,
	output logic                                     s_tready,
	// command, phys_addr, range_len, seg_index from bit 0 up, zero padded
	input  wire  [((ADDR_BITS + 40 + 7) / 8) * 8-1:0] s_tdata,
	output logic                                     m_tvalid,
	input  wire                                      m_tready,
	// status, seg_count, seg_phys, seg_len from bit 0 up, zero padded
	output logic [((ADDR_BITS + 41 + 7) / 8) * 8-1:0] m_tdata,
	input  wire                                      psel,
	input  wire                                      penable,
	input  wire                                      pwrite,
	input  wire  [sgl_pkg::PADDR_W-1:0]              paddr,
	input  wire  [sgl_pkg::PDATA_W-1:0]              pwdata,
	output logic [sgl_pkg::PDATA_W-1:0]              prdata,
	output logic                                     pready
);

	localparam int OUT_W = ((ADDR_BITS + 41 + 7) / 8) * 8;

	sgl_pkg::cfg_t     cfg;
	sgl_pkg::dp_cmd_t  cmd;
	sgl_pkg::dp_stat_t stat;

	logic [1:0]           status;
	logic [6:0]           seg_count;
	logic [ADDR_BITS-1:0] seg_phys;
	logic [31:0]          seg_len;

	sgl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sgl_dp #(
		.SEG_DEPTH (SEG_DEPTH),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.command   (s_tdata[1:0]),
		.phys_addr (s_tdata[ADDR_BITS+1:2]),
		.range_len (s_tdata[ADDR_BITS+33:ADDR_BITS+2]),
		.seg_index (s_tdata[ADDR_BITS+39:ADDR_BITS+34]),
		.status    (status),
		.seg_count (seg_count),
		.seg_phys  (seg_phys),
		.seg_len   (seg_len)
	);

	assign m_tdata = OUT_W'({seg_len, seg_phys, seg_count, status});

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: stream and register testbench for the segment list builder
// A queue-fed driver sends clear, append, read and unused commands. A
// predictor keeps its own segment table and register copy and computes the
// expected result of every accepted item. The monitor checks each result
// against the oldest expectation. Phases change the registers while the
// block is idle and vary the idling on both stream sides.
// ---------------------------------------------------------------------------
module tb_top;
	import sgl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int TBL_DEPTH = 64;
	localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;
	localparam int PHASE_ITEMS = 210;
	localparam int HOLDOFF_CYCLES = 400;

	// First declared field sits in the highest bits.
	typedef struct packed {
		logic [5:0]  seg_index;
		logic [31:0] range_len;
		logic [47:0] phys_addr;
		logic [1:0]  command;
	} sg_req_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [31:0] seg_len;
		logic [47:0] seg_phys;
		logic [6:0]  seg_count;
		logic [1:0]  status;
	} seg_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	// command, phys_addr, range_len, seg_index from bit 0 up
	logic [87:0]         s_tdata = '0;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	// status, seg_count, seg_phys, seg_len from bit 0 up, zero padded
	wire  [95:0]         m_tdata;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	wire  [PDATA_W-1:0]  prdata;
	wire                 pready;

	sg_segment_list_builder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Register copies and segment table of the predictor.
	logic [31:0] cfg_seg_size = MAX_SEG_SIZE_RST;
	logic [32:0] cfg_bnd = '0;
	logic [6:0]  cfg_max_segs = MAX_SEGS_RST;
	logic [47:0] tbl_start [TBL_DEPTH];
	logic [31:0] tbl_len [TBL_DEPTH];
	int          tbl_total = 0;

	sg_req_t     cmd_backlog[$];
	seg_result_t want_results[$];
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          hold_go = 1'b0;
	logic        hold_on = 1'b0;
	logic [47:0] next_addr_hint = '0;

	function automatic seg_result_t segment_step(input sg_req_t req);
		seg_result_t r;
		logic [63:0] bnd, maxsz, cap, addr, len, piece, room, merged, seg_end, seg_st;
		int          k;
		bit          done, merge_ok;
		r = '0;
		case (req.command)
			CMD_CLEAR: tbl_total = 0;
			CMD_APPEND: begin
				bnd = '0;
				for (int i = 0; i < 33; i++)
					if (cfg_bnd[i]) bnd = 64'd1 << i;
				maxsz = (cfg_seg_size == 0) ? 64'd1 : 64'(cfg_seg_size);
				cap = (cfg_max_segs > TBL_DEPTH) ? 64'(TBL_DEPTH) : 64'(cfg_max_segs);
				addr = 64'(req.phys_addr);
				len = 64'(req.range_len);
				done = 1'b0;
				while (len != 0 && !done) begin
					piece = (len > maxsz) ? maxsz : len;
					if (bnd != 0) begin
						room = bnd - (addr & (bnd - 1));
						if (room < piece) piece = room;
					end
					merge_ok = 1'b0;
					if (tbl_total != 0) begin
						k = tbl_total - 1;
						seg_st = 64'(tbl_start[k]);
						seg_end = (seg_st + 64'(tbl_len[k])) & ADDR_MASK;
						merged = 64'(tbl_len[k]) + piece;
						// The merged segment must stay inside one boundary window.
						if (seg_end == addr && merged <= maxsz &&
						    (bnd == 0 || ((seg_st & ~(bnd - 1)) ==
						                  ((seg_st + merged - 1) & ~(bnd - 1)))))
							merge_ok = 1'b1;
					end
					if (merge_ok) begin
						tbl_len[k] = merged[31:0];
					end else if (tbl_total >= cap) begin
						r.status = ST_FULL;
						done = 1'b1;
					end else begin
						tbl_start[tbl_total] = addr[47:0];
						tbl_len[tbl_total] = piece[31:0];
						tbl_total++;
					end
					if (!done) begin
						addr = (addr + piece) & ADDR_MASK;
						len = len - piece;
					end
				end
			end
			CMD_READ: begin
				if (int'(req.seg_index) < tbl_total) begin
					r.seg_phys = tbl_start[req.seg_index];
					r.seg_len = tbl_len[req.seg_index];
				end else begin
					r.status = ST_NOIDX;
				end
			end
			default: ;
		endcase
		r.seg_count = 7'(tbl_total);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
	endtask

	task automatic check_result(input seg_result_t got);
		seg_result_t want;
		if (want_results.size() == 0) begin
			report_mismatch("unexpected result", 64'(got), '0);
		end else begin
			want = want_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.seg_count !== want.seg_count)
				report_mismatch("seg_count", 64'(got.seg_count), 64'(want.seg_count));
			if (got.seg_phys !== want.seg_phys)
				report_mismatch("seg_phys", 64'(got.seg_phys), 64'(want.seg_phys));
			if (got.seg_len !== want.seg_len)
				report_mismatch("seg_len", 64'(got.seg_len), 64'(want.seg_len));
			if (got.pad !== 7'd0)
				report_mismatch("tdata padding", 64'(got.pad), '0);
		end
	endtask

	// Input driver: the prediction is made at the edge that accepts the item.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			want_results.push_back(segment_step(sg_req_t'(s_tdata)));
		if (!s_tvalid || s_tready) begin
			if (arst_n && cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tdata <= cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result(seg_result_t'(m_tdata));
		m_tready <= arst_n && !hold_on && ($urandom_range(99) >= rx_stall_pct);
	end

	// Long receiver hold-off so that the block backs up into its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic queue_item(input logic [1:0] cmd, input logic [47:0] addr,
	                          input logic [31:0] len, input logic [5:0] idx);
		sg_req_t it;
		it.command = cmd;
		it.phys_addr = addr;
		it.range_len = len;
		it.seg_index = idx;
		cmd_backlog.push_back(it);
	endtask

	// Mostly appends, many of which continue the previous range, so that merging,
	// splitting and table-full cases are reached; the rest is noise.
	function automatic sg_req_t make_random_item(input logic [31:0] seg_size,
	                                             input bit no_clear);
		sg_req_t     it;
		logic [95:0] raw;
		logic [31:0] lim;
		int          sel, pick;
		raw = {$urandom, $urandom, $urandom};
		it = raw[87:0];
		sel = $urandom_range(99);
		if (sel < 10 && !no_clear) begin
			it.command = CMD_CLEAR;
		end else if (sel < 13) begin
			it.command = CMD_UNUSED;
		end else if (sel < 45) begin
			it.command = CMD_READ;
			if ($urandom_range(99) < 60) it.seg_index = 6'($urandom_range(15));
		end else begin
			it.command = CMD_APPEND;
			pick = $urandom_range(99);
			if (pick < 65)
				it.phys_addr = next_addr_hint;
			else if (pick < 72)
				it.phys_addr = {32'hFFFF_FFFF, 16'($urandom)};
			lim = (seg_size == 0 || seg_size > 32'h10000) ? 32'h10000 : seg_size;
			pick = $urandom_range(99);
			if (pick < 4)
				it.range_len = '0;
			else if (pick < 60)
				it.range_len = $urandom_range(lim, 1);
			else if (pick < 92)
				it.range_len = $urandom_range(3 * lim, 1);
			next_addr_hint = it.phys_addr + 48'(it.range_len);
		end
		return it;
	endfunction

	task automatic wait_drained;
		while (cmd_backlog.size() != 0 || s_tvalid || want_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MAX_SEG_SIZE: cfg_seg_size = val[31:0];
			REG_BOUNDARY:     cfg_bnd = val[32:0];
			REG_MAX_SEGS:     cfg_max_segs = val[6:0];
			default: ;
		endcase
	endtask

	logic [31:0] ph_seg_size [8] = '{32'd4096, 32'd4096, 32'd1, 32'hFFFF_FFFF,
	                                 32'd65536, 32'd0, 32'd3000, 32'd65536};
	logic [32:0] ph_bnd [8] = '{33'd0, 33'h1_0000, 33'd1, 33'h1_0000_0000,
	                            33'h3000, 33'h1_8000_0001, 33'h3000, 33'h1000};
	logic [6:0]  ph_max_segs [8] = '{7'd64, 7'd64, 7'd1, 7'd64,
	                                 7'd0, 7'd127, 7'd64, 7'd3};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset register values.
		queue_item(CMD_READ, '0, '0, 6'd0);
		queue_item(CMD_UNUSED, '1, '1, '1);
		queue_item(CMD_APPEND, 48'h1000, 32'd0, '0);
		queue_item(CMD_APPEND, 48'h1000, 32'h100, '0);
		queue_item(CMD_APPEND, 48'h1100, 32'h200, '0);
		queue_item(CMD_APPEND, 48'h1300, 32'h2_0000, '0);
		queue_item(CMD_APPEND, 48'hFFFF_FFFF_FF00, 32'h200, '0);
		// Continues the previous range past the top of the address space.
		queue_item(CMD_APPEND, 48'h100, 32'h10, '0);
		for (int i = 0; i < 5; i++)
			queue_item(CMD_READ, '1, '1, 6'(i));
		queue_item(CMD_READ, '0, '0, 6'd63);
		queue_item(CMD_APPEND, 48'h0, 32'hFFFF_FFFF, '0);
		queue_item(CMD_READ, '0, '0, 6'd63);
		queue_item(CMD_APPEND, 48'h7777_0000_0000, 32'd1, '1);
		queue_item(CMD_CLEAR, '0, '0, '0);
		queue_item(CMD_READ, '0, '0, 6'd0);
		queue_item(CMD_APPEND, 48'hFFFF_FFFF_FFFF, 32'd2, '0);
		queue_item(CMD_READ, '0, '0, 6'd0);
		queue_item(CMD_READ, '0, '0, 6'd1);
		queue_item(CMD_CLEAR, '1, '1, '1);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			repeat (4) @(posedge clk);
			reg_write(REG_MAX_SEG_SIZE, 64'(ph_seg_size[p]));
			reg_write(REG_BOUNDARY, 64'(ph_bnd[p]));
			reg_write(REG_MAX_SEGS, 64'(ph_max_segs[p]));
			case (p % 4)
				0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct <= 55; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct <= 0;  rx_stall_pct <= 55; end
				default: begin tx_idle_pct <= 10; rx_stall_pct <= 10; end
			endcase
			// The first items of a phase keep the table, so a lowered
			// max_segs meets a table that is already over it.
			for (int n = 0; n < PHASE_ITEMS / 2; n++)
				cmd_backlog.push_back(make_random_item(ph_seg_size[p], n < 40));
			if (p == 1)
				hold_go = 1'b1;
			if (p == 2)
				wait_drained();
			for (int n = 0; n < PHASE_ITEMS / 2; n++)
				cmd_backlog.push_back(make_random_item(ph_seg_size[p], 1'b0));
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/sgl_pkg.sv
sv/sgl_ram.sv
sv/sgl_regs.sv
sv/sgl_ctrl.sv
sv/sgl_dp.sv
sv/sg_segment_list_builder_top.sv
verif/tb_top.sv
